// ===== rtl/pfe_pkg.sv =====
`timescale 1ns / 1ps

package pfe_pkg;

    localparam int LETTER_W = 5;
    localparam int LETTERS = 26;
    localparam int SQ_SIDE = 5;
    localparam int SQ_AREA = SQ_SIDE * SQ_SIDE;
    localparam int QUEUE_DEPTH = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [LETTER_W-1:0] CODE_I = 5'd8;
    localparam logic [LETTER_W-1:0] CODE_J = 5'd9;
    localparam logic [LETTER_W-1:0] CODE_X = 5'd23;
    localparam logic [LETTER_W-1:0] CODE_Z = 5'd25;

    localparam logic [2:0] SIDE_LAST = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LETTERS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 2'd1;

    // one digraph job, optionally followed by (first_letter, x) closing the message
    typedef struct packed {
        logic [LETTER_W-1:0] first_letter;
        logic [LETTER_W-1:0] second_letter;
        logic                last;
        logic                extra;
    } pfe_job_t;

    function automatic logic [2:0] pos_row(input logic [LETTER_W-1:0] pos);
        logic [2:0] row;
        priority if (pos >= 5'd20) row = 3'd4;
        else if (pos >= 5'd15) row = 3'd3;
        else if (pos >= 5'd10) row = 3'd2;
        else if (pos >= 5'd5) row = 3'd1;
        else row = 3'd0;
        return row;
    endfunction

    function automatic logic [LETTER_W-1:0] row_base(input logic [2:0] row);
        logic [LETTER_W-1:0] base;
        base = 5'({2'b00, row} << 2) + 5'(row);
        return base;
    endfunction

    function automatic logic [2:0] pos_col(input logic [LETTER_W-1:0] pos);
        logic [LETTER_W-1:0] diff;
        diff = pos - row_base(pos_row(pos));
        return diff[2:0];
    endfunction

    function automatic logic [2:0] wrap_inc(input logic [2:0] v);
        logic [2:0] r;
        r = (v == SIDE_LAST) ? 3'd0 : 3'(v + 3'd1);
        return r;
    endfunction

    function automatic logic [LETTER_W-1:0] pos_of(input logic [2:0] row, input logic [2:0] col);
        logic [LETTER_W-1:0] p;
        p = row_base(row) + 5'(col);
        return p;
    endfunction

endpackage

// ===== rtl/pfe_front.sv =====
`timescale 1ns / 1ps

module pfe_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [pfe_pkg::LETTER_W-1:0] plain_letter,
    input  logic                      message_end,
    input  logic                      push_ready,
    output logic                      push,
    output pfe_pkg::pfe_job_t         push_job
);

    logic [pfe_pkg::LETTER_W-1:0] held_letter_reg;
    logic [pfe_pkg::LETTER_W-1:0] held_letter_next;
    logic                         held_valid_reg;
    logic                         held_valid_next;
    logic                         accept;
    logic [pfe_pkg::LETTER_W-1:0] letter;

    assign in_ready = push_ready;
    assign accept = in_valid && push_ready;

    // saturate, then fold j onto i
    always_comb
    begin
        letter = (plain_letter > pfe_pkg::CODE_Z) ? pfe_pkg::CODE_Z : plain_letter;
        if (letter == pfe_pkg::CODE_J)
        begin
            letter = pfe_pkg::CODE_I;
        end
    end

    always_comb
    begin
        held_letter_next = held_letter_reg;
        held_valid_next = held_valid_reg;
        push = 1'b0;
        push_job.first_letter = letter;
        push_job.second_letter = pfe_pkg::CODE_X;
        push_job.last = 1'b1;
        push_job.extra = 1'b0;
        if (accept)
        begin
            if (held_valid_reg && (letter != held_letter_reg))
            begin
                push = 1'b1;
                push_job.first_letter = held_letter_reg;
                push_job.second_letter = letter;
                push_job.last = message_end;
                held_valid_next = 1'b0;
            end
            else if (held_valid_reg)
            begin
                // doubled letter: x goes between, the new letter is held or closed out
                push = 1'b1;
                push_job.first_letter = held_letter_reg;
                push_job.last = 1'b0;
                push_job.extra = message_end;
                held_valid_next = !message_end;
                held_letter_next = letter;
            end
            else if (message_end)
            begin
                push = 1'b1;
                held_valid_next = 1'b0;
            end
            else
            begin
                held_valid_next = 1'b1;
                held_letter_next = letter;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_letter_reg <= '0;
            held_valid_reg <= 1'b0;
        end
        else
        begin
            held_letter_reg <= held_letter_next;
            held_valid_reg <= held_valid_next;
        end
    end

endmodule

// ===== rtl/pfe_queue.sv =====
`timescale 1ns / 1ps

module pfe_queue (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  pfe_pkg::pfe_job_t         push_job,
    output logic                      push_ready,
    input  logic                      pop,
    output logic                      head_valid,
    output pfe_pkg::pfe_job_t         head_job
);

    localparam int PTR_W = $clog2(pfe_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(pfe_pkg::QUEUE_DEPTH + 1);

    pfe_pkg::pfe_job_t entry_reg [pfe_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign push_ready = (count_reg != CNT_W'(pfe_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(pfe_pkg::QUEUE_DEPTH))
        else $error("job queue count beyond depth");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("job queue popped while empty");

endmodule

// ===== rtl/pfe_back.sv =====
`timescale 1ns / 1ps

module pfe_back #(
    parameter int MAX_KEY_LETTERS = 7
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_fire,
    input  logic [pfe_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [pfe_pkg::LETTER_W*MAX_KEY_LETTERS-1:0] cfg_data,
    input  logic                                  head_valid,
    input  pfe_pkg::pfe_job_t                     head_job,
    output logic                                  pop,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [pfe_pkg::LETTER_W-1:0]          cipher_letter,
    output logic                                  last_result
);

    localparam int KEY_W = pfe_pkg::LETTER_W * MAX_KEY_LETTERS;
    localparam int BUILD_STEPS = MAX_KEY_LETTERS + pfe_pkg::LETTERS;
    localparam int STEP_W = $clog2(BUILD_STEPS);
    localparam int KIDX_W = (MAX_KEY_LETTERS > 1) ? $clog2(MAX_KEY_LETTERS) : 1;
    localparam logic [pfe_pkg::LETTERS-1:0] MASK_INIT =
        pfe_pkg::LETTERS'(1) << pfe_pkg::CODE_J;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SQ   = 2'd1;
    localparam logic [1:0] S_OUT0 = 2'd2;
    localparam logic [1:0] S_OUT1 = 2'd3;

    // configuration
    logic [KEY_W-1:0] key_letters_reg;
    logic [2:0]       key_length_reg;

    // square builder
    logic                         build_active_reg;
    logic [STEP_W-1:0]            step_reg;
    logic [pfe_pkg::LETTER_W-1:0] filled_reg;
    logic [pfe_pkg::LETTERS-1:0]  mask_reg;
    logic                         key_phase;
    logic [KIDX_W-1:0]            kidx;
    logic [pfe_pkg::LETTER_W-1:0] cand;
    logic                         cand_free;
    logic                         place_en;
    logic                         build_done;
    logic                         build_restart;

    // square and letter map
    logic [pfe_pkg::LETTER_W-1:0] sq_mem  [pfe_pkg::SQ_AREA];
    logic [pfe_pkg::LETTER_W-1:0] pos_mem [pfe_pkg::LETTERS];

    // encoder
    logic [1:0]                   state_reg;
    logic [1:0]                   state_next;
    logic [pfe_pkg::LETTER_W-1:0] job_a_reg;
    logic                         job_last_reg;
    logic                         job_extra_reg;
    logic [pfe_pkg::LETTER_W-1:0] pos1_reg;
    logic [pfe_pkg::LETTER_W-1:0] pos2_reg;
    logic [pfe_pkg::LETTER_W-1:0] sq1_reg;
    logic [pfe_pkg::LETTER_W-1:0] sq2_reg;
    logic                         pos_rd;
    logic [pfe_pkg::LETTER_W-1:0] pos_addr1;
    logic [pfe_pkg::LETTER_W-1:0] pos_addr2;
    logic [2:0]                   r1;
    logic [2:0]                   c1;
    logic [2:0]                   r2;
    logic [2:0]                   c2;
    logic [pfe_pkg::LETTER_W-1:0] q1;
    logic [pfe_pkg::LETTER_W-1:0] q2;
    logic                         out_free;
    logic                         out_load;
    logic [pfe_pkg::LETTER_W-1:0] out_letter_next;
    logic                         out_last_next;
    logic                         out_valid_reg;
    logic [pfe_pkg::LETTER_W-1:0] out_letter_reg;
    logic                         out_last_reg;

    // ---------------- square builder ----------------
    assign key_phase = (step_reg < STEP_W'(MAX_KEY_LETTERS));
    assign kidx = step_reg[KIDX_W-1:0];
    assign build_done = (step_reg == STEP_W'(BUILD_STEPS - 1));
    assign build_restart = cfg_fire && ((cfg_index == pfe_pkg::REG_KEY_LETTERS) ||
                                        (cfg_index == pfe_pkg::REG_KEY_LENGTH));

    always_comb
    begin
        if (key_phase)
        begin
            cand = key_letters_reg[pfe_pkg::LETTER_W*kidx +: pfe_pkg::LETTER_W];
        end
        else
        begin
            cand = pfe_pkg::LETTER_W'(step_reg - STEP_W'(MAX_KEY_LETTERS));
        end
        cand_free = (cand <= pfe_pkg::CODE_Z) ? !mask_reg[cand] : 1'b0;
        place_en = build_active_reg && cand_free &&
                   (!key_phase || (step_reg < STEP_W'(key_length_reg)));
    end

    always_ff @(posedge clk)
    begin
        if (place_en)
        begin
            sq_mem[filled_reg] <= cand;
            pos_mem[cand] <= filled_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_letters_reg <= '0;
            key_length_reg <= 3'd1;
            build_active_reg <= 1'b1;
            step_reg <= '0;
            filled_reg <= '0;
            mask_reg <= MASK_INIT;
        end
        else
        begin
            if (build_restart)
            begin
                // a key letters or key length write starts the build over
                build_active_reg <= 1'b1;
                step_reg <= '0;
                filled_reg <= '0;
                mask_reg <= MASK_INIT;
            end
            else if (build_active_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (place_en)
                begin
                    filled_reg <= filled_reg + 1'b1;
                    mask_reg[cand] <= 1'b1;
                end
                if (build_done)
                begin
                    build_active_reg <= 1'b0;
                end
            end
            if (cfg_fire)
            begin
                unique case (cfg_index)
                    pfe_pkg::REG_KEY_LETTERS:
                    begin
                        key_letters_reg <= cfg_data;
                    end
                    pfe_pkg::REG_KEY_LENGTH:
                    begin
                        key_length_reg <= cfg_data[2:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // ---------------- digraph encoder ----------------
    assign out_free = !out_valid_reg || out_ready;
    assign pop = (state_reg == S_IDLE) && head_valid && !build_active_reg;
    assign pos_rd = pop || ((state_reg == S_OUT1) && out_free && job_extra_reg);
    assign pos_addr1 = (state_reg == S_IDLE) ? head_job.first_letter : job_a_reg;
    assign pos_addr2 = (state_reg == S_IDLE) ? head_job.second_letter : pfe_pkg::CODE_X;

    always_comb
    begin
        r1 = pfe_pkg::pos_row(pos1_reg);
        c1 = pfe_pkg::pos_col(pos1_reg);
        r2 = pfe_pkg::pos_row(pos2_reg);
        c2 = pfe_pkg::pos_col(pos2_reg);
        if (r1 == r2)
        begin
            q1 = pfe_pkg::pos_of(r1, pfe_pkg::wrap_inc(c1));
            q2 = pfe_pkg::pos_of(r2, pfe_pkg::wrap_inc(c2));
        end
        else if (c1 == c2)
        begin
            q1 = pfe_pkg::pos_of(pfe_pkg::wrap_inc(r1), c1);
            q2 = pfe_pkg::pos_of(pfe_pkg::wrap_inc(r2), c2);
        end
        else
        begin
            q1 = pfe_pkg::pos_of(r1, c2);
            q2 = pfe_pkg::pos_of(r2, c1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (pos_rd)
        begin
            pos1_reg <= pos_mem[pos_addr1];
            pos2_reg <= pos_mem[pos_addr2];
        end
        if (state_reg == S_SQ)
        begin
            sq1_reg <= sq_mem[q1];
            sq2_reg <= sq_mem[q2];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        out_load = 1'b0;
        out_letter_next = sq1_reg;
        out_last_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (pop)
                begin
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                state_next = S_OUT0;
            end
            S_OUT0:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    state_next = S_OUT1;
                end
            end
            S_OUT1:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    out_letter_next = sq2_reg;
                    out_last_next = job_last_reg;
                    state_next = job_extra_reg ? S_SQ : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_a_reg <= head_job.first_letter;
        end
        if (out_load)
        begin
            out_letter_reg <= out_letter_next;
            out_last_reg <= out_last_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            job_last_reg <= 1'b0;
            job_extra_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop)
            begin
                job_last_reg <= head_job.last;
                job_extra_reg <= head_job.extra;
            end
            else if ((state_reg == S_OUT1) && out_free && job_extra_reg)
            begin
                // closing pair (letter, x) ends the message
                job_last_reg <= 1'b1;
                job_extra_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign cipher_letter = out_letter_reg;
    assign last_result = out_last_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        filled_reg <= pfe_pkg::LETTER_W'(pfe_pkg::SQ_AREA))
        else $error("square fill count beyond square area");

    a_build_complete: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(build_active_reg) |->
            (&mask_reg) && (filled_reg == pfe_pkg::LETTER_W'(pfe_pkg::SQ_AREA)))
        else $error("square build ended without placing every letter");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT0 || state_reg == S_OUT1))
        else $error("result shown outside a result state");

endmodule

// ===== rtl/playfair_stream_encoder.sv =====
`timescale 1ns / 1ps

// Playfair stream encoder: plaintext letters (0 = a) go in one item at a time and
// cipher letters come out in digraphs, with last_result marking the final letter of a
// message. Letters above z saturate to z and j is read as i; a doubled letter gets x
// between, and an odd final letter is padded with x. The 5x5 key square is rebuilt
// after reset and after every key letters or key length write; the build walks the key
// letters and then the alphabet one candidate per cycle, and no digraph is encoded until
// it finishes. A front stage pairs the letters and takes one item per cycle while a
// two-entry job queue has room. The back end handles a digraph as a letter map read,
// a square read and the result states S_OUT0 and S_OUT1, and pops a new job only from
// idle; the closing pair of a doubled letter at message end does its map read in the
// last result state of the first pair and then takes the square read and the result
// states again. Configuration writes are always accepted and are meant for idle
// periods; a held letter survives a write and uses the new square.
module playfair_stream_encoder #(
    parameter int MAX_KEY_LETTERS = 7
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration write channel
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [pfe_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [pfe_pkg::LETTER_W*MAX_KEY_LETTERS-1:0] cfg_data,
    // plaintext item channel
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [pfe_pkg::LETTER_W-1:0]          plain_letter,
    input  logic                                  message_end,
    // cipher item channel
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [pfe_pkg::LETTER_W-1:0]          cipher_letter,
    output logic                                  last_result
);

    logic              push;
    logic              push_ready;
    pfe_pkg::pfe_job_t push_job;
    logic              pop;
    logic              head_valid;
    pfe_pkg::pfe_job_t head_job;
    logic              cfg_fire;

    // register file never back-pressures
    assign cfg_ready = 1'b1;
    assign cfg_fire = cfg_valid && cfg_ready;

    // front: j folding, letter hold and digraph pairing
    pfe_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .plain_letter (plain_letter),
        .message_end  (message_end),
        .push_ready   (push_ready),
        .push         (push),
        .push_job     (push_job)
    );

    // short job queue decoupling pairing from encoding
    pfe_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .push_ready (push_ready),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    // back: key square build, digraph rules and output register
    pfe_back #(
        .MAX_KEY_LETTERS (MAX_KEY_LETTERS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_fire      (cfg_fire),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .head_valid    (head_valid),
        .head_job      (head_job),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .cipher_letter (cipher_letter),
        .last_result   (last_result)
    );

endmodule
